/* src/vrot_pkg.sv */
package vrot_pkg;

  localparam int XW = 50;
  localparam int ZW = 34;
  localparam int NTAB = 30;

  localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

  localparam logic [31:0] ATAN_TAB [NTAB] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] angle_deg;
  } vec_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
  } vec_out_t;

  typedef struct packed {
    logic                 vld;
    logic                 bypass;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
  } cord_t;

endpackage

/* src/vrot_front.sv */
module vrot_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vrot_pkg::vec_in_t vec_in,
  output vrot_pkg::cord_t   cord
);

  localparam int HW   = 29 - FRAC_BITS;
  localparam int HUW  = HW + 1;
  localparam int LW   = FRAC_BITS + 3;
  localparam int OFF  = 45 * ((2 ** (HW - 1) + 44) / 45);
  localparam int S1   = HUW + 6;
  localparam int RW1  = S1 - 5;
  localparam int PW1  = HUW + RW1;
  localparam int QW   = PW1 - S1;
  localparam logic [RW1-1:0] RECIP1 = RW1'((2 ** S1 + 44) / 45);
  localparam logic [22:0]    RECIP2 = 23'((2 ** 28 + 44) / 45);
  localparam logic [32:0]    QT     = 33'd95443717;

  typedef struct packed {
    logic               vld;
    logic               zero;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } side_t;

  side_t                          a_s, b_s, c_s, d_s;
  logic [HUW-1:0]                 a_hu;
  logic [LW-1:0]                  a_l, b_l;
  logic [PW1-1:0]                 a_prod;
  logic signed [63:0]             a_px, a_py;
  logic [5:0]                     b_d;
  logic signed [vrot_pkg::XW-1:0] b_x, b_y, c_x, c_y, d_x, d_y;
  logic [21:0]                    c_w;
  logic [32:0]                    c_base, d_base;
  logic [44:0]                    d_prod;

  logic [HW-1:0]                  h;
  logic [HUW-1:0]                 hu;
  logic signed [63:0]             px_p, py_p;
  logic [QW-1:0]                  q;
  logic [HUW-1:0]                 q45;
  logic [32:0]                    lv, v;
  logic [15:0]                    av;
  logic [16:0]                    bv;
  logic [31:0]                    ph, phf;
  logic                           flip;
  vrot_pkg::cord_t                cord_next;

  assign h    = vec_in.angle_deg[31:LW];
  assign hu   = {h[HW-1], h} + HUW'(OFF);
  assign px_p = vec_in.vec_x * vrot_pkg::GAIN_Q31;
  assign py_p = vec_in.vec_y * vrot_pkg::GAIN_Q31;

  assign q    = a_prod[PW1-1:S1];
  assign q45  = HUW'(q) * HUW'(45);

  assign lv   = {1'b0, b_l, {(29 - FRAC_BITS){1'b0}}} + 33'd22;
  assign v    = lv + 33'(b_d) * 33'd31;
  assign av   = v[32:17];
  assign bv   = v[16:0];

  assign ph   = 32'(d_base + 33'(d_prod[44:28]));
  assign flip = ph[31] ^ ph[30];
  assign phf  = {ph[31] ^ flip, ph[30:0]};

  always_comb begin
    cord_next.vld    = d_s.vld;
    cord_next.bypass = d_s.zero;
    cord_next.flip   = flip;
    cord_next.x      = d_x;
    cord_next.y      = d_y;
    cord_next.z      = {{(vrot_pkg::ZW - 32){phf[31]}}, phf};
    cord_next.px     = d_s.vx;
    cord_next.py     = d_s.vy;
  end

  always_ff @(posedge clk) begin
    a_s.vld  <= start;
    a_s.zero <= (vec_in.angle_deg == 32'sd0);
    a_s.vx   <= vec_in.vec_x;
    a_s.vy   <= vec_in.vec_y;
    a_hu     <= hu;
    a_l      <= vec_in.angle_deg[LW-1:0];
    a_prod   <= PW1'(hu) * PW1'(RECIP1);
    a_px     <= px_p;
    a_py     <= py_p;

    b_s <= a_s;
    b_l <= a_l;
    b_d <= 6'(a_hu - q45);
    b_x <= vrot_pkg::XW'((a_px + 64'sd16384) >>> 15);
    b_y <= vrot_pkg::XW'((a_py + 64'sd16384) >>> 15);

    c_s    <= b_s;
    c_w    <= 22'({av, 5'b0}) + 22'(bv);
    c_base <= 33'(b_d) * QT + 33'(av) * 33'd2912;
    c_x    <= b_x;
    c_y    <= b_y;

    d_s    <= c_s;
    d_prod <= 45'(c_w) * 45'(RECIP2);
    d_base <= c_base;
    d_x    <= c_x;
    d_y    <= c_y;

    cord <= cord_next;

    if (rst) begin
      a_s.vld  <= 1'b0;
      b_s.vld  <= 1'b0;
      c_s.vld  <= 1'b0;
      d_s.vld  <= 1'b0;
      cord.vld <= 1'b0;
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    b_s.vld |-> (b_d < 6'd45))
    else $error("turn digit out of range");

  a_phase_folded: assert property (@(posedge clk) disable iff (rst)
    cord.vld |-> ($countones(cord.z[vrot_pkg::ZW-1:30]) == 0 ||
                  $countones(cord.z[vrot_pkg::ZW-1:30]) == vrot_pkg::ZW - 30))
    else $error("folded phase outside half turn");

endmodule

/* src/vrot_stage.sv */
module vrot_stage #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  vrot_pkg::cord_t cin,
  output vrot_pkg::cord_t cout
);

  logic signed [vrot_pkg::XW-1:0] dx, dy;
  logic signed [vrot_pkg::ZW-1:0] t;
  vrot_pkg::cord_t                cout_next;

  always_comb begin
    dx        = cin.y >>> IDX;
    dy        = cin.x >>> IDX;
    t         = vrot_pkg::ZW'(vrot_pkg::ATAN_TAB[IDX]);
    cout_next = cin;
    if (!cin.z[vrot_pkg::ZW-1]) begin
      cout_next.x = cin.x - dx;
      cout_next.y = cin.y + dy;
      cout_next.z = cin.z - t;
    end else begin
      cout_next.x = cin.x + dx;
      cout_next.y = cin.y - dy;
      cout_next.z = cin.z + t;
    end
  end

  always_ff @(posedge clk) begin
    cout <= cout_next;
    if (rst) begin
      cout.vld <= 1'b0;
    end
  end

endmodule

/* src/vrot_back.sv */
module vrot_back (
  input  logic               clk,
  input  logic               rst,
  input  vrot_pkg::cord_t    cin,
  output logic               done,
  output vrot_pkg::vec_out_t vec_out
);

  localparam logic signed [vrot_pkg::XW-1:0] HALF = vrot_pkg::XW'(32768);
  localparam logic signed [vrot_pkg::XW-1:0] MAXV = vrot_pkg::XW'(64'sh7FFFFFFF);
  localparam logic signed [vrot_pkg::XW-1:0] MINV = -(MAXV + vrot_pkg::XW'(1));

  logic signed [vrot_pkg::XW-1:0] sx, sy, rx, ry;
  logic signed [31:0]             ox, oy;
  vrot_pkg::vec_out_t             vec_out_next;

  always_comb begin
    sx = cin.flip ? -cin.x : cin.x;
    sy = cin.flip ? -cin.y : cin.y;
    rx = (sx + HALF) >>> 16;
    ry = (sy + HALF) >>> 16;
    if (rx > MAXV) begin
      ox = 32'sh7FFFFFFF;
    end else if (rx < MINV) begin
      ox = 32'sh80000000;
    end else begin
      ox = rx[31:0];
    end
    if (ry > MAXV) begin
      oy = 32'sh7FFFFFFF;
    end else if (ry < MINV) begin
      oy = 32'sh80000000;
    end else begin
      oy = ry[31:0];
    end
    vec_out_next.rot_x = cin.bypass ? cin.px : ox;
    vec_out_next.rot_y = cin.bypass ? cin.py : oy;
  end

  always_ff @(posedge clk) begin
    vec_out <= vec_out_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cin.vld;
    end
  end

endmodule

/* src/vector_rotate_2d.sv */
// Channel   Ports                      Transfer
// -------   ------------------------   ------------------------------------
// input     start, busy, vec_in        rising edge with start high, busy low
// output    done, vec_out              rising edge ending the cycle done is high
//
// The pipeline has five stages that build the phase and the gain-scaled vector,
// one stage per CORDIC micro-rotation and one output stage.
// One vector enters every cycle; busy stays low.
// Synchronous reset flushes all valid bits; no results come out of flushed items.
// The receiver cannot stall, so results leave on a fixed schedule.
module vector_rotate_2d #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vrot_pkg::vec_in_t  vec_in,
  output logic               done,
  output vrot_pkg::vec_out_t vec_out
);

  localparam int NS  = (CORDIC_STAGES > vrot_pkg::NTAB) ? vrot_pkg::NTAB : CORDIC_STAGES;
  localparam int LAT = NS + 6;

  vrot_pkg::cord_t chain [NS+1];
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  vrot_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .vec_in(vec_in),
    .cord  (chain[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_stage
    vrot_stage #(
      .IDX(i)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .cin (chain[i]),
      .cout(chain[i+1])
    );
  end

  vrot_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cin    (chain[NS]),
    .done   (done),
    .vec_out(vec_out)
  );

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without matching transfer");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("transfer produced no result");

  a_zero_angle_pass: assert property (@(posedge clk) disable iff (rst)
    (done && $past(vec_in.angle_deg == 32'sd0, LAT)) |->
      (vec_out.rot_x == $past(vec_in.vec_x, LAT) &&
       vec_out.rot_y == $past(vec_in.vec_y, LAT)))
    else $error("zero angle did not pass vector through");

endmodule
